// ===== hdl/edc_pkg.sv =====
package edc_pkg;

	localparam int unsigned DIA_RESET = 32'd655360;
	localparam int unsigned NUM_W = 114;
	localparam int unsigned DEN_W = 81;
	localparam int unsigned Q_W = 41;
	localparam int unsigned FRONT_STAGES = 8;
	localparam int unsigned DIV_LAT = Q_W + 1;
	localparam int unsigned POST_STAGES = 2;
	localparam int unsigned LATENCY = FRONT_STAGES + DIV_LAT + POST_STAGES;
	localparam int unsigned LANES = 4;

	localparam logic [Q_W-1:0] Q_CLAMP = {1'b1, {(Q_W-1){1'b0}}};

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [Q_W-1:0] quot_t;

	typedef struct packed {
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
	} vel_t;

	typedef struct packed {
		vel_t vel;
		logic neg_x;
		logic neg_y;
		logic collided;
		logic coincident;
	} side_t;

endpackage

// ===== hdl/edc_front.sv =====
module edc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [31:0]   self_x,
	input  logic signed [31:0]   self_y,
	input  logic signed [31:0]   self_vx,
	input  logic signed [31:0]   self_vy,
	input  logic [15:0]          self_mass,
	input  logic signed [31:0]   other_x,
	input  logic signed [31:0]   other_y,
	input  logic signed [31:0]   other_vx,
	input  logic signed [31:0]   other_vy,
	input  logic [15:0]          other_mass,
	input  logic [31:0]          dia,
	output logic                 out_valid,
	output edc_pkg::side_t       side,
	output edc_pkg::num_t        num [edc_pkg::LANES],
	output edc_pkg::den_t        den
);
	import edc_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	vel_t        vel_s1, vel_s2, vel_s3;
	side_t       side_s4, side_s5, side_s6, side_s7, side_s8;

	logic [31:0] dxm_s1, dym_s1, dvxm_s1, dvym_s1;
	logic        sdx_s1, sdy_s1, sdvx_s1, sdvy_s1;
	logic [15:0] m1_s1, m2_s1, m1_s2, m2_s2, m1_s3, m2_s3, m1_s4, m2_s4;
	logic [15:0] m1_s5, m2_s5, m1_s6, m2_s6;
	logic [16:0] msum_s1, msum_s2, msum_s3;
	logic [63:0] dsq_s1, dsq_s2, dsq_s3;

	logic [63:0] sx_s2, sy_s2, tx_s2, ty_s2;
	logic [31:0] dxm_s2, dym_s2, dxm_s3, dym_s3, dxm_s4, dym_s4;
	logic        sdx_s2, sdy_s2, sdx_s3, sdy_s3, nx_s2, ny_s2;

	logic [64:0] sep_s3;
	logic [65:0] ip_s3;

	logic [64:0] ipm_s4;
	logic [48:0] dpl_s4, dph_s4;

	den_t        den_s5, den_s6, den_s7, den_s8;
	logic [63:0] pxl_s5, pyl_s5;
	logic [64:0] pxh_s5, pyh_s5;

	logic [96:0] px_s6, py_s6;

	logic [48:0] c0_s7 [LANES];
	logic [48:0] c1_s7 [LANES];
	logic [49:0] c2_s7 [LANES];

	num_t        num_s8 [LANES];

	logic [65:0] txs, tys, ipc;
	logic        ip_neg;
	logic [16:0] tm [LANES];
	logic [96:0] pax [LANES];

	always_comb begin
		txs = nx_s2 ? (66'd0 - {2'b00, tx_s2}) : {2'b00, tx_s2};
		tys = ny_s2 ? (66'd0 - {2'b00, ty_s2}) : {2'b00, ty_s2};
		ip_neg = ip_s3[65];
		ipc = ip_neg ? (66'd0 - ip_s3) : ip_s3;
		for (int l = 0; l < LANES; l++) begin
			tm[l] = (l < 2) ? {m2_s6, 1'b0} : {m1_s6, 1'b0};
			pax[l] = l[0] ? py_s6 : px_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		sdx_s1  <= self_x < other_x;
		sdy_s1  <= self_y < other_y;
		sdvx_s1 <= self_vx < other_vx;
		sdvy_s1 <= self_vy < other_vy;
		dxm_s1  <= (self_x < other_x) ? $unsigned(other_x) - $unsigned(self_x)
		                             : $unsigned(self_x) - $unsigned(other_x);
		dym_s1  <= (self_y < other_y) ? $unsigned(other_y) - $unsigned(self_y)
		                             : $unsigned(self_y) - $unsigned(other_y);
		dvxm_s1 <= (self_vx < other_vx) ? $unsigned(other_vx) - $unsigned(self_vx)
		                               : $unsigned(self_vx) - $unsigned(other_vx);
		dvym_s1 <= (self_vy < other_vy) ? $unsigned(other_vy) - $unsigned(self_vy)
		                               : $unsigned(self_vy) - $unsigned(other_vy);
		m1_s1   <= self_mass;
		m2_s1   <= other_mass;
		msum_s1 <= 17'(self_mass) + 17'(other_mass);
		dsq_s1  <= 64'(dia) * 64'(dia);
		vel_s1  <= '{v1x: self_vx, v1y: self_vy, v2x: other_vx, v2y: other_vy};

		sx_s2   <= 64'(dxm_s1) * 64'(dxm_s1);
		sy_s2   <= 64'(dym_s1) * 64'(dym_s1);
		tx_s2   <= 64'(dvxm_s1) * 64'(dxm_s1);
		ty_s2   <= 64'(dvym_s1) * 64'(dym_s1);
		nx_s2   <= sdvx_s1 ^ sdx_s1;
		ny_s2   <= sdvy_s1 ^ sdy_s1;
		sdx_s2  <= sdx_s1;
		sdy_s2  <= sdy_s1;
		dxm_s2  <= dxm_s1;
		dym_s2  <= dym_s1;
		m1_s2   <= m1_s1;
		m2_s2   <= m2_s1;
		msum_s2 <= msum_s1;
		dsq_s2  <= dsq_s1;
		vel_s2  <= vel_s1;

		sep_s3  <= {1'b0, sx_s2} + {1'b0, sy_s2};
		ip_s3   <= txs + tys;
		sdx_s3  <= sdx_s2;
		sdy_s3  <= sdy_s2;
		dxm_s3  <= dxm_s2;
		dym_s3  <= dym_s2;
		m1_s3   <= m1_s2;
		m2_s3   <= m2_s2;
		msum_s3 <= msum_s2;
		dsq_s3  <= dsq_s2;
		vel_s3  <= vel_s2;

		ipm_s4  <= ipc[64:0];
		dpl_s4  <= 49'(sep_s3[31:0]) * 49'(msum_s3);
		dph_s4  <= 49'(sep_s3[63:32]) * 49'(msum_s3);
		side_s4.vel        <= vel_s3;
		side_s4.neg_x      <= ip_neg ^ sdx_s3;
		side_s4.neg_y      <= ip_neg ^ sdy_s3;
		side_s4.collided   <= !sep_s3[64] && (sep_s3[63:0] != 64'd0)
		                      && (sep_s3[63:0] <= dsq_s3) && (msum_s3 != 17'd0);
		side_s4.coincident <= !sep_s3[64] && (sep_s3[63:0] == 64'd0);
		dxm_s4  <= dxm_s3;
		dym_s4  <= dym_s3;
		m1_s4   <= m1_s3;
		m2_s4   <= m2_s3;

		den_s5  <= {dph_s4, 32'd0} + 81'(dpl_s4);
		pxl_s5  <= 64'(ipm_s4[31:0]) * 64'(dxm_s4);
		pxh_s5  <= 65'(ipm_s4[64:32]) * 65'(dxm_s4);
		pyl_s5  <= 64'(ipm_s4[31:0]) * 64'(dym_s4);
		pyh_s5  <= 65'(ipm_s4[64:32]) * 65'(dym_s4);
		side_s5 <= side_s4;
		m1_s5   <= m1_s4;
		m2_s5   <= m2_s4;

		px_s6   <= {pxh_s5, 32'd0} + 97'(pxl_s5);
		py_s6   <= {pyh_s5, 32'd0} + 97'(pyl_s5);
		den_s6  <= den_s5;
		side_s6 <= side_s5;
		m1_s6   <= m1_s5;
		m2_s6   <= m2_s5;

		for (int l = 0; l < LANES; l++) begin
			c0_s7[l] <= 49'(pax[l][31:0]) * 49'(tm[l]);
			c1_s7[l] <= 49'(pax[l][63:32]) * 49'(tm[l]);
			c2_s7[l] <= 50'(pax[l][96:64]) * 50'(tm[l]);
		end
		den_s7  <= den_s6;
		side_s7 <= side_s6;

		for (int l = 0; l < LANES; l++) begin
			num_s8[l] <= NUM_W'(c0_s7[l]) + (NUM_W'(c1_s7[l]) << 32)
			             + (NUM_W'(c2_s7[l]) << 64);
		end
		den_s8  <= den_s7;
		side_s8 <= side_s7;
	end

	assign out_valid = valid_s8;
	assign side = side_s8;
	assign num = num_s8;
	assign den = den_s8;

endmodule

// ===== hdl/edc_div.sv =====
module edc_div (
	input  logic            clk,
	input  edc_pkg::num_t   num,
	input  edc_pkg::den_t   den,
	output edc_pkg::quot_t  quot,
	output logic            ovf
);
	import edc_pkg::*;

	localparam int unsigned CMP_W = DEN_W + Q_W;

	num_t  r_s [0:Q_W-1];
	den_t  d_s [0:Q_W-1];
	quot_t q_s [1:Q_W];
	logic  ovf_s [0:Q_W];

	always_ff @(posedge clk) begin
		r_s[0]   <= num;
		d_s[0]   <= den;
		ovf_s[0] <= {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
	end

	for (genvar gi = 0; gi < Q_W; gi++) begin : g_step
		localparam int unsigned K = Q_W - 1 - gi;
		logic [CMP_W-1:0] trial, rem, diff;
		logic             take;
		quot_t            q_prev;

		always_comb begin
			trial = {{(CMP_W-DEN_W){1'b0}}, d_s[gi]} << K;
			rem   = {{(CMP_W-NUM_W){1'b0}}, r_s[gi]};
			take  = rem >= trial;
			diff  = rem - trial;
		end

		if (gi == 0) begin : g_first
			assign q_prev = '0;
		end else begin : g_next
			assign q_prev = q_s[gi];
		end

		always_ff @(posedge clk) begin
			q_s[gi+1]   <= {q_prev[Q_W-2:0], take};
			ovf_s[gi+1] <= ovf_s[gi];
		end

		if (gi < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				r_s[gi+1] <= take ? diff[NUM_W-1:0] : r_s[gi];
				d_s[gi+1] <= d_s[gi];
			end
		end
	end

	assign quot = q_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

// ===== hdl/edc_delay.sv =====
module edc_delay #(
	parameter int unsigned DEPTH = edc_pkg::DIV_LAT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  edc_pkg::side_t  in_side,
	output logic            out_valid,
	output edc_pkg::side_t  out_side
);
	import edc_pkg::*;

	logic  valid_q [DEPTH];
	side_t side_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
		end else begin
			valid_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) valid_q[i] <= valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= in_side;
		for (int i = 1; i < DEPTH; i++) side_q[i] <= side_q[i-1];
	end

	assign out_valid = valid_q[DEPTH-1];
	assign out_side = side_q[DEPTH-1];

endmodule

// ===== hdl/edc_post.sv =====
module edc_post (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  edc_pkg::side_t      side,
	input  edc_pkg::quot_t      quot [edc_pkg::LANES],
	input  logic                ovf [edc_pkg::LANES],
	output logic                done,
	output logic signed [31:0]  new_self_vx,
	output logic signed [31:0]  new_self_vy,
	output logic signed [31:0]  new_other_vx,
	output logic signed [31:0]  new_other_vy,
	output logic                collided,
	output logic                coincident,
	output logic                saturated
);
	import edc_pkg::*;

	logic  valid_s1, valid_s2;
	side_t side_s1;
	quot_t qe_s1 [LANES];

	logic signed [31:0] vout_s2 [LANES];
	logic               coll_s2, coin_s2, sat_s2;

	logic signed [31:0] vin [LANES];
	logic               sub [LANES];
	logic signed [Q_W+1:0] sum [LANES];
	logic signed [31:0] vsat [LANES];
	logic               lsat [LANES];

	always_comb begin
		vin[0] = side_s1.vel.v1x;
		vin[1] = side_s1.vel.v1y;
		vin[2] = side_s1.vel.v2x;
		vin[3] = side_s1.vel.v2y;
		sub[0] = !side_s1.neg_x;
		sub[1] = !side_s1.neg_y;
		sub[2] = side_s1.neg_x;
		sub[3] = side_s1.neg_y;
		for (int l = 0; l < LANES; l++) begin
			sum[l] = sub[l] ? (($bits(sum[l]))'(vin[l]) - $signed({2'b00, qe_s1[l]}))
			                : (($bits(sum[l]))'(vin[l]) + $signed({2'b00, qe_s1[l]}));
			lsat[l] = 1'b0;
			vsat[l] = sum[l][31:0];
			if (sum[l] > $signed(($bits(sum[l]))'(32'sh7fffffff))) begin
				lsat[l] = 1'b1;
				vsat[l] = 32'sh7fffffff;
			end else if (sum[l] < -$signed(($bits(sum[l]))'(33'sh080000000))) begin
				lsat[l] = 1'b1;
				vsat[l] = 32'sh80000000;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side;
		for (int l = 0; l < LANES; l++) begin
			qe_s1[l] <= (ovf[l] || quot[l] > Q_CLAMP) ? Q_CLAMP : quot[l];
		end

		coll_s2 <= side_s1.collided;
		coin_s2 <= side_s1.coincident;
		if (side_s1.collided) begin
			for (int l = 0; l < LANES; l++) vout_s2[l] <= vsat[l];
			sat_s2 <= lsat[0] | lsat[1] | lsat[2] | lsat[3];
		end else begin
			for (int l = 0; l < LANES; l++) vout_s2[l] <= vin[l];
			sat_s2 <= 1'b0;
		end
	end

	assign done = valid_s2;
	assign new_self_vx = vout_s2[0];
	assign new_self_vy = vout_s2[1];
	assign new_other_vx = vout_s2[2];
	assign new_other_vy = vout_s2[3];
	assign collided = coll_s2;
	assign coincident = coin_s2;
	assign saturated = sat_s2;

endmodule

// ===== hdl/elastic_disc_collision_unit.sv =====
// Path: an accepted pair passes through the registered front stages, the divider lanes and the post stages to done.
// Throughput: one pair per cycle; busy is never raised and results cannot be held off.
// The depth is set by the 41-step restoring divider pipeline, one quotient bit per stage.
// Reset: arst_n clears all valid bits at once and returns contact_diameter to 10.0;
// data registers are not reset.
module elastic_disc_collision_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] self_x,
	input  logic signed [31:0] self_y,
	input  logic signed [31:0] self_vx,
	input  logic signed [31:0] self_vy,
	input  logic [15:0]        self_mass,
	input  logic signed [31:0] other_x,
	input  logic signed [31:0] other_y,
	input  logic signed [31:0] other_vx,
	input  logic signed [31:0] other_vy,
	input  logic [15:0]        other_mass,
	output logic               done,
	output logic signed [31:0] new_self_vx,
	output logic signed [31:0] new_self_vy,
	output logic signed [31:0] new_other_vx,
	output logic signed [31:0] new_other_vy,
	output logic               collided,
	output logic               coincident,
	output logic               saturated
);
	import edc_pkg::*;

	logic [31:0] dia_q;
	logic        front_valid, div_valid;
	side_t       front_side, div_side;
	num_t        num [LANES];
	den_t        den;
	quot_t       quot [LANES];
	logic        ovf [LANES];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dia_q <= DIA_RESET;
		end else if (cfg_we) begin
			dia_q <= cfg_data;
		end
	end

	edc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.self_x     (self_x),
		.self_y     (self_y),
		.self_vx    (self_vx),
		.self_vy    (self_vy),
		.self_mass  (self_mass),
		.other_x    (other_x),
		.other_y    (other_y),
		.other_vx   (other_vx),
		.other_vy   (other_vy),
		.other_mass (other_mass),
		.dia        (dia_q),
		.out_valid  (front_valid),
		.side       (front_side),
		.num        (num),
		.den        (den)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_div
		edc_div u_div (
			.clk  (clk),
			.num  (num[l]),
			.den  (den),
			.quot (quot[l]),
			.ovf  (ovf[l])
		);
	end

	edc_delay #(.DEPTH(DIV_LAT)) u_delay (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_side   (front_side),
		.out_valid (div_valid),
		.out_side  (div_side)
	);

	edc_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (div_valid),
		.side         (div_side),
		.quot         (quot),
		.ovf          (ovf),
		.done         (done),
		.new_self_vx  (new_self_vx),
		.new_self_vy  (new_self_vy),
		.new_other_vx (new_other_vx),
		.new_other_vy (new_other_vy),
		.collided     (collided),
		.coincident   (coincident),
		.saturated    (saturated)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##52 done)
		else $error("transaction result missing");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(collided && coincident))
		else $error("collided and coincident together");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !collided) |-> !saturated)
		else $error("saturation without collision");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned SETTLE = edc_pkg::LATENCY + 4;

	typedef struct {
		logic signed [31:0] sx, sy, svx, svy, ox, oy, ovx, ovy;
		logic [15:0] sm, om;
		int unsigned gap;
	} pair_t;

	typedef struct {
		logic signed [31:0] s_vx, s_vy, o_vx, o_vy;
		logic hit, same_centre, clipped;
	} bounce_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;
	logic signed [31:0] self_x = '0, self_y = '0, self_vx = '0, self_vy = '0;
	logic signed [31:0] other_x = '0, other_y = '0, other_vx = '0, other_vy = '0;
	logic [15:0] self_mass = 16'd1, other_mass = 16'd1;
	logic done;
	logic signed [31:0] new_self_vx, new_self_vy, new_other_vx, new_other_vy;
	logic collided, coincident, saturated;

	pair_t pending_pairs[$];
	bounce_t expected_bounces[$];
	logic [31:0] dia_now = edc_pkg::DIA_RESET;
	int unsigned gap_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_pairs = 0, n_hits = 0, n_same = 0, n_clip = 0, n_errors = 0;

	elastic_disc_collision_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.self_x(self_x), .self_y(self_y), .self_vx(self_vx), .self_vy(self_vy),
		.self_mass(self_mass),
		.other_x(other_x), .other_y(other_y), .other_vx(other_vx), .other_vy(other_vy),
		.other_mass(other_mass),
		.done(done),
		.new_self_vx(new_self_vx), .new_self_vy(new_self_vy),
		.new_other_vx(new_other_vx), .new_other_vy(new_other_vy),
		.collided(collided), .coincident(coincident), .saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [43:0] velocity_shift(logic signed [69:0] ip,
			logic signed [33:0] d_axis, logic [15:0] m_other, logic [191:0] den);
		logic [191:0] num, q, ip_mag, d_mag;
		ip_mag = 192'(ip < 0 ? -ip : ip);
		d_mag = 192'(d_axis < 0 ? -d_axis : d_axis);
		num = ip_mag * d_mag * (192'(m_other) << 1);
		q = num / den;
		if (q > (192'(1) << 40))
			q = 192'(1) << 40;
		return ((ip < 0) != (d_axis < 0)) ? -$signed(44'(q)) : $signed(44'(q));
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [47:0] v, inout logic flag);
		if (v > 48'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -48'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic bounce_t predict_bounce(pair_t p, logic [31:0] dia);
		bounce_t r;
		logic signed [33:0] dx, dy, dvx, dvy;
		logic signed [69:0] ip;
		logic [65:0] sep;
		logic [63:0] dia_sq;
		logic [191:0] den;
		logic [16:0] msum;
		logic flag;
		dx = p.sx - p.ox;
		dy = p.sy - p.oy;
		dvx = p.svx - p.ovx;
		dvy = p.svy - p.ovy;
		sep = 66'(dx * dx) + 66'(dy * dy);
		dia_sq = {32'b0, dia} * {32'b0, dia};
		msum = {1'b0, p.sm} + {1'b0, p.om};
		flag = 1'b0;
		r.s_vx = p.svx;
		r.s_vy = p.svy;
		r.o_vx = p.ovx;
		r.o_vy = p.ovy;
		r.same_centre = (sep == 0);
		r.hit = sep != 0 && sep[65:64] == 2'b00 && sep[63:0] <= dia_sq && msum != 0;
		if (r.hit) begin
			ip = 70'(dvx) * 70'(dx) + 70'(dvy) * 70'(dy);
			den = 192'(sep) * 192'(msum);
			r.s_vx = clip32(48'(p.svx) - 48'(velocity_shift(ip, dx, p.om, den)), flag);
			r.s_vy = clip32(48'(p.svy) - 48'(velocity_shift(ip, dy, p.om, den)), flag);
			r.o_vx = clip32(48'(p.ovx) + 48'(velocity_shift(ip, dx, p.sm, den)), flag);
			r.o_vy = clip32(48'(p.ovy) + 48'(velocity_shift(ip, dy, p.sm, den)), flag);
		end
		r.clipped = flag;
		return r;
	endfunction

	function automatic logic [15:0] rand_mass();
		case ($urandom_range(0, 5))
			0: return 16'd1;
			1: return 16'hffff;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic signed [31:0] rand_speed();
		return $signed(32'($urandom)) >>> $urandom_range(0, 24);
	endfunction

	function automatic pair_t random_pair(logic [31:0] dia, bit bursty);
		pair_t p;
		logic [31:0] reach;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		reach = (dia >> 1) + (dia >> 2);
		p.sx = $urandom;
		p.sy = $urandom;
		p.svx = rand_speed();
		p.svy = rand_speed();
		p.ovx = rand_speed();
		p.ovy = rand_speed();
		p.sm = rand_mass();
		p.om = rand_mass();
		if (kind == 0) begin
			p.ox = $urandom;
			p.oy = $urandom;
		end else if (kind == 1) begin
			p.ox = p.sx;
			p.oy = p.sy;
		end else begin
			p.ox = p.sx - ($urandom_range(0, 1) ? -$urandom_range(0, reach)
				: $urandom_range(0, reach));
			p.oy = p.sy - ($urandom_range(0, 1) ? -$urandom_range(0, reach)
				: $urandom_range(0, reach));
		end
		p.gap = bursty ? 0 : $urandom_range(0, 10);
		return p;
	endfunction

	function automatic pair_t fixed_pair(logic signed [31:0] sx, sy, svx, svy,
			logic [15:0] sm, logic signed [31:0] ox, oy, ovx, ovy, logic [15:0] om);
		pair_t p;
		p = '{sx: sx, sy: sy, svx: svx, svy: svy, sm: sm,
			ox: ox, oy: oy, ovx: ovx, ovy: ovy, om: om, gap: $urandom_range(0, 3)};
		return p;
	endfunction

	always @(posedge clk) begin : drive_pairs
		pair_t nxt;
		logic next_start;
		if (start && !busy) begin
			expected_bounces.push_back(predict_bounce('{sx: self_x, sy: self_y,
				svx: self_vx, svy: self_vy, sm: self_mass, ox: other_x, oy: other_y,
				ovx: other_vx, ovy: other_vy, om: other_mass, gap: 0}, dia_now));
			n_pairs++;
		end
		if (!start || !busy) begin
			next_start = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_pairs.size() != 0) begin
				nxt = pending_pairs.pop_front();
				gap_left = nxt.gap;
				if (gap_left == 0) begin
					next_start = 1'b1;
					self_x <= nxt.sx;
					self_y <= nxt.sy;
					self_vx <= nxt.svx;
					self_vy <= nxt.svy;
					self_mass <= nxt.sm;
					other_x <= nxt.ox;
					other_y <= nxt.oy;
					other_vx <= nxt.ovx;
					other_vy <= nxt.ovy;
					other_mass <= nxt.om;
				end else
					pending_pairs.push_front('{sx: nxt.sx, sy: nxt.sy, svx: nxt.svx,
						svy: nxt.svy, sm: nxt.sm, ox: nxt.ox, oy: nxt.oy, ovx: nxt.ovx,
						ovy: nxt.ovy, om: nxt.om, gap: 0});
			end
			start <= next_start;
		end
	end

	always @(posedge clk) begin : check_bounces
		bounce_t e;
		if (arst_n && done) begin
			if (expected_bounces.size() == 0) begin
				$error("result with no transaction outstanding");
				n_errors++;
			end else begin
				e = expected_bounces.pop_front();
				if (new_self_vx !== e.s_vx) begin
					$error("new_self_vx: expected %0d, actual %0d", e.s_vx, new_self_vx);
					n_errors++;
				end
				if (new_self_vy !== e.s_vy) begin
					$error("new_self_vy: expected %0d, actual %0d", e.s_vy, new_self_vy);
					n_errors++;
				end
				if (new_other_vx !== e.o_vx) begin
					$error("new_other_vx: expected %0d, actual %0d", e.o_vx, new_other_vx);
					n_errors++;
				end
				if (new_other_vy !== e.o_vy) begin
					$error("new_other_vy: expected %0d, actual %0d", e.o_vy, new_other_vy);
					n_errors++;
				end
				if (collided !== e.hit) begin
					$error("collided: expected %0d, actual %0d", e.hit, collided);
					n_errors++;
				end
				if (coincident !== e.same_centre) begin
					$error("coincident: expected %0d, actual %0d", e.same_centre, coincident);
					n_errors++;
				end
				if (saturated !== e.clipped) begin
					$error("saturated: expected %0d, actual %0d", e.clipped, saturated);
					n_errors++;
				end
				n_hits += e.hit;
				n_same += e.same_centre;
				n_clip += e.clipped;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_pairs.size() != 0 || gap_left != 0 || start
			|| expected_bounces.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_diameter(logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		dia_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int unsigned count);
		bit bursty;
		bursty = 1'b0;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0)
				bursty = ($urandom_range(0, 2) == 0);
			pending_pairs.push_back(random_pair(dia_now, bursty));
		end
	endtask

	initial begin : stimulus
		logic [31:0] dia_steps[5];
		dia_steps = '{32'hffffffff, 32'd0, 32'd65536, 32'h0, edc_pkg::DIA_RESET};
		dia_steps[3] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_pairs.push_back(fixed_pair(0, 0, 32'sh10000, 0, 16'h100,
			32'sh40000, 0, -32'sh10000, 0, 16'h100));
		pending_pairs.push_back(fixed_pair(0, 0, 32'sh10000, 32'sh20000, 16'h100,
			32'sh30000, 32'sh30000, 0, 0, 16'h300));
		pending_pairs.push_back(fixed_pair(32'sh12345, -32'sh777, 5, 7, 16'h80,
			32'sh12345, -32'sh777, -9, 3, 16'h200));
		pending_pairs.push_back(fixed_pair(0, 0, 1, 1, 16'h100,
			32'sh100000, 32'sh100000, 0, 0, 16'h100));
		pending_pairs.push_back(fixed_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 16'hffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 16'hffff));
		pending_pairs.push_back(fixed_pair(32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000,
			16'd1, 32'sh80000000 + 32'sh8000, 32'sh4000, 32'sh80000000, 32'sh7fffffff,
			16'hffff));
		pending_pairs.push_back(fixed_pair(0, 0, 32'sh80000000, 32'sh7fffffff, 16'hffff,
			1, 0, 32'sh7fffffff, 32'sh80000000, 16'd1));
		pending_pairs.push_back(fixed_pair(0, 0, 0, 0, 16'd1, 1, 1, 0, 0, 16'd1));
		pending_pairs.push_back(fixed_pair(-5, 9, 32'sh7fffffff, -1, 16'hffff,
			-5, 9, 32'sh80000000, 1, 16'hffff));
		pending_pairs.push_back(fixed_pair(0, 0, 32'sh50000, -32'sh50000, 16'h100,
			32'sha0000, 0, 0, 0, 16'h100));
		pending_pairs.push_back(fixed_pair(0, 0, 32'sh50000, -32'sh50000, 16'h100,
			32'sha0001, 0, 0, 0, 16'h100));
		pending_pairs.push_back(fixed_pair(-32'sh30000, 32'sh20000, 32'sh7fffffff,
			32'sh7fffffff, 16'd1, 0, 0, 32'sh80000000, 32'sh80000000, 16'hffff));
		queue_random(130);
		wait_drained();

		foreach (dia_steps[k]) begin
			write_diameter(dia_steps[k]);
			if (dia_steps[k] == 32'hffffffff) begin
				pending_pairs.push_back(fixed_pair(32'sh7fffffff, 0, 0, 0, 16'd1,
					32'sh80000000, 0, 32'sh7fffffff, 0, 16'd1));
				pending_pairs.push_back(fixed_pair(32'sh7fffffff, 32'sh7fffffff, 1, 2,
					16'hffff, 32'sh80000000, 32'sh80000000, 3, 4, 16'd1));
			end
			queue_random(k == 4 ? 60 : 110);
			wait_drained();
		end

		$display("Ran %0d disc pairs over 6 contact diameters: %0d collisions, %0d coincident,",
			n_pairs, n_hits, n_same);
		$display("%0d with clipped velocities, %0d mismatches", n_clip, n_errors);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/edc_pkg.sv
hdl/edc_front.sv
hdl/edc_div.sv
hdl/edc_delay.sv
hdl/edc_post.sv
hdl/elastic_disc_collision_unit.sv
tb/tb.sv
